// ===== hdl/stuffed_frame_receiver_assert.svh =====
// Assertion macros used by the RTL.
`ifndef STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define STUFFED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// Next-cycle implication, disabled during reset.
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_BYTE = 2'd1;
  localparam op_t OP_READ = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ACCEPT = 2'd0;
  localparam kind_t KIND_REPLY  = 2'd1;
  localparam kind_t KIND_READ   = 2'd2;

  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] END_BYTE   = 8'hAA;
  localparam logic [7:0] ESC_BYTE   = 8'hFF;
  localparam logic [7:0] REPLY_HDR0 = 8'h00;
  localparam logic [7:0] REPLY_HDR1 = 8'h20;
  localparam logic [7:0] CMD_FLAG   = 8'h80;
  localparam logic [7:0] STATUS_LEN_ERR   = 8'h00;
  localparam logic [7:0] STATUS_NO_TARGET = 8'h01;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_IDLE_TICKS = 3'd0;
  localparam cfg_idx_t REG_TARGET_A   = 3'd1;
  localparam cfg_idx_t REG_TARGET_B   = 3'd2;
  localparam cfg_idx_t REG_TARGET_C   = 3'd3;
  localparam cfg_idx_t REG_TARGET_D   = 3'd4;

  localparam logic [15:0] IDLE_TICKS_RST = 16'd50;
  localparam logic [7:0]  TARGET_A_RST   = 8'd1;
  localparam logic [7:0]  TARGET_B_RST   = 8'd2;
  localparam logic [7:0]  TARGET_C_RST   = 8'd3;
  localparam logic [7:0]  TARGET_D_RST   = 8'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = 2;
  localparam int FCNT_W     = 3;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_ESC  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] handler;
    logic [7:0] command;
    logic [9:0] payload_length;
    logic [7:0] data_byte;
    logic       last;
  } out_item_t;

  // data_byte holds the status byte for reply jobs
  typedef struct packed {
    kind_t      kind;
    logic [1:0] handler;
    logic [7:0] command;
    logic [9:0] payload_length;
    logic [7:0] data_byte;
  } job_t;

endpackage

// ===== hdl/stuffed_frame_receiver.sv =====
// Byte-stuffed frame receiver with idle timeout.
// Input channel (in_valid/in_ready, in_data): one transfer per serial byte,
// idle tick or frame store read. Configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data): idle reload and four target codes, always ready;
// write it only while the block is idle.
// Result channel (out_valid/out_ready, out_data): an accepted-frame report
// or a store read is one transfer; a failed frame gives a stuffed error
// reply of 6 or 7 transfers, the final one flagged by last.
// Throughput: one input transfer per cycle while in_ready is high, set by
// the single frame store write or read per cycle. Results pass through the
// stage-one job register, a 4-entry job FIFO and an output register (store
// read data comes through the registered RAM read port); when the receiver
// stalls, results hold; in_ready drops once FIFO and stage one hold 4 jobs.
// Each reply job drains at one transfer per cycle while out_ready is high.
// Reset (synchronous, rst_n low): hunting phase, countdown, byte count and
// overflow cleared, registers to defaults, queues empty. The frame store is
// not cleared; unwritten entries read as undefined.
`include "stuffed_frame_receiver_assert.svh"

module stuffed_frame_receiver #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfr_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  sfr_pkg::cfg_idx_t   cfg_index,
  input  logic [15:0]         cfg_data
);

  import sfr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic [15:0] idle_ticks_r;
  logic [7:0]  tgt_r [4];

  phase_t      phase_r, phase_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        ovf_r, ovf_nxt;
  logic [7:0]  b0_r, b1_r, b2_r;

  logic        s1_valid_r;
  job_t        s1_job_r;
  logic        s1_read_r;
  logic        s1_range_r;
  job_t        job_nxt;
  logic        job_req;

  job_t        fifo_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0] cnt_r;
  logic [2:0]  beat_r;

  logic        out_valid_r;
  out_item_t   out_r;

  logic        in_acc, byte_acc, tick_acc, read_acc;
  logic        is_start, is_end, is_esc, is_special, start_hit;
  logic        store_req, finish_req, room;
  logic        mem_we;
  logic [7:0]  mem_rdata;
  logic [AW-1:0] rd_addr;
  logic        rd_in_range;

  logic        len_ok, matched;
  logic [1:0]  match_idx;
  logic [7:0]  fin_cmd;

  job_t        push_job, head;
  logic        push, pop, ld;
  logic [7:0]  reply_cmd;
  logic        reply_esc, beat_last;
  logic [2:0]  last_beat;
  out_item_t   beat_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ticks_r <= IDLE_TICKS_RST;
      tgt_r[0]     <= TARGET_A_RST;
      tgt_r[1]     <= TARGET_B_RST;
      tgt_r[2]     <= TARGET_C_RST;
      tgt_r[3]     <= TARGET_D_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IDLE_TICKS: idle_ticks_r <= cfg_data;
        REG_TARGET_A:   tgt_r[0] <= cfg_data[7:0];
        REG_TARGET_B:   tgt_r[1] <= cfg_data[7:0];
        REG_TARGET_C:   tgt_r[2] <= cfg_data[7:0];
        REG_TARGET_D:   tgt_r[3] <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input side
  assign in_ready = ({1'b0, cnt_r} + {{FCNT_W{1'b0}}, s1_valid_r}) < (FCNT_W + 1)'(FIFO_DEPTH);
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_data.operation == OP_TICK);
  assign byte_acc = in_acc && (in_data.operation == OP_BYTE);
  assign read_acc = in_acc && (in_data.operation == OP_READ);

  assign is_start   = in_data.rx_byte == START_BYTE;
  assign is_end     = in_data.rx_byte == END_BYTE;
  assign is_esc     = in_data.rx_byte == ESC_BYTE;
  assign is_special = is_start || is_end || is_esc;
  assign start_hit  = (countdown_r == '0) && (phase_r == PH_HUNT) && is_start;

  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      unique case (in_data.operation)
        OP_TICK: begin
          if (countdown_r == '0) phase_nxt = PH_HUNT;
        end
        OP_BYTE: begin
          if (start_hit) begin
            phase_nxt = PH_DATA;
          end else begin
            unique case (phase_r)
              PH_DATA: begin
                if (is_esc)        phase_nxt = PH_ESC;
                else if (is_start) phase_nxt = PH_HUNT;
                else if (is_end)   phase_nxt = PH_DONE;
              end
              PH_ESC:  phase_nxt = is_special ? PH_DATA : PH_HUNT;
              PH_HUNT: ;
              PH_DONE: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign store_req  = byte_acc && !start_hit &&
                      (((phase_r == PH_DATA) && !is_special) ||
                       ((phase_r == PH_ESC) && is_special));
  assign finish_req = byte_acc && !start_hit && (phase_r == PH_DATA) && is_end;
  assign room       = 32'(count_r) < STORE_DEPTH;
  assign mem_we     = store_req && room;

  always_comb begin
    countdown_nxt = countdown_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    if (tick_acc && (countdown_r != '0)) countdown_nxt = countdown_r - 16'd1;
    if (byte_acc) countdown_nxt = idle_ticks_r;
    if (byte_acc && start_hit) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (store_req) begin
      if (room) count_nxt = count_r + CW'(1);
      else      ovf_nxt   = 1'b1;
    end
  end

  // frame check
  assign fin_cmd = (count_r >= CW'(3)) ? b2_r : 8'h00;
  assign len_ok  = !ovf_r && (count_r >= CW'(3)) &&
                   (32'(count_r) == ({16'h0000, b0_r, b1_r} + 32'd2));

  always_comb begin
    matched   = 1'b0;
    match_idx = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (fin_cmd == tgt_r[i]) begin
        matched   = 1'b1;
        match_idx = 2'(i);
      end
    end
  end

  always_comb begin
    job_nxt = '0;
    if (read_acc) begin
      job_nxt.kind = KIND_READ;
    end else if (len_ok && matched) begin
      job_nxt.kind           = KIND_ACCEPT;
      job_nxt.handler        = match_idx;
      job_nxt.command        = fin_cmd;
      job_nxt.payload_length = 10'(count_r - CW'(3));
    end else begin
      job_nxt.kind      = KIND_REPLY;
      job_nxt.command   = fin_cmd;
      job_nxt.data_byte = len_ok ? STATUS_NO_TARGET : STATUS_LEN_ERR;
    end
  end
  assign job_req = read_acc || finish_req;

  assign rd_addr     = AW'(in_data.read_index);
  assign rd_in_range = 32'(in_data.read_index) < STORE_DEPTH;

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_data.rx_byte),
    .re    (read_acc),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      countdown_r <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      countdown_r <= countdown_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      s1_valid_r  <= job_req;
    end
  end

  // copies of the length word and command, written with the store, and the stage-one job
  always_ff @(posedge clk) begin
    if (mem_we && (count_r == CW'(0))) b0_r <= in_data.rx_byte;
    if (mem_we && (count_r == CW'(1))) b1_r <= in_data.rx_byte;
    if (mem_we && (count_r == CW'(2))) b2_r <= in_data.rx_byte;
    if (job_req) begin
      s1_job_r   <= job_nxt;
      s1_read_r  <= read_acc;
      s1_range_r <= rd_in_range;
    end
  end

  // job FIFO
  always_comb begin
    push_job = s1_job_r;
    if (s1_read_r) push_job.data_byte = s1_range_r ? mem_rdata : 8'h00;
  end
  assign push = s1_valid_r;
  assign head = fifo_r[rd_ptr_r];

  // reply expansion
  assign reply_cmd = head.command | CMD_FLAG;
  assign reply_esc = (reply_cmd == START_BYTE) || (reply_cmd == END_BYTE) ||
                     (reply_cmd == ESC_BYTE);
  assign last_beat = reply_esc ? 3'd6 : 3'd5;
  assign beat_last = (head.kind != KIND_REPLY) || (beat_r == last_beat);

  always_comb begin
    beat_item                = '0;
    beat_item.kind           = head.kind;
    beat_item.command        = head.command;
    beat_item.last           = beat_last;
    if (head.kind == KIND_REPLY) begin
      case (beat_r)
        3'd0:    beat_item.data_byte = START_BYTE;
        3'd1:    beat_item.data_byte = REPLY_HDR0;
        3'd2:    beat_item.data_byte = REPLY_HDR1;
        3'd3:    beat_item.data_byte = reply_esc ? ESC_BYTE : reply_cmd;
        3'd4:    beat_item.data_byte = reply_esc ? reply_cmd : head.data_byte;
        3'd5:    beat_item.data_byte = reply_esc ? head.data_byte : END_BYTE;
        default: beat_item.data_byte = END_BYTE;
      endcase
    end else begin
      beat_item.handler        = head.handler;
      beat_item.payload_length = head.payload_length;
      beat_item.data_byte      = head.data_byte;
    end
  end

  assign ld  = (cnt_r != '0) && (!out_valid_r || out_ready);
  assign pop = ld && beat_last;

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= push_job;
    if (ld)   out_r <= beat_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FPTR_W'(1);
      cnt_r <= cnt_r + FCNT_W'(push) - FCNT_W'(pop);
      if (pop)     beat_r <= '0;
      else if (ld) beat_r <= beat_r + 3'd1;
      if (ld)             out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SFR_ASSERT_IMP(a_fifo_bound, clk, rst_n, 1'b1, cnt_r <= FCNT_W'(FIFO_DEPTH))
  `SFR_ASSERT_IMP(a_push_room, clk, rst_n, s1_valid_r, cnt_r < FCNT_W'(FIFO_DEPTH))
  `SFR_ASSERT_IMP(a_beat_bound, clk, rst_n, cnt_r != '0, beat_r <= last_beat)
  `SFR_ASSERT_NXT(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= STORE_DEPTH)

endmodule

// ===== hdl/sfr_ram.sv =====
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sfr_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam op_t OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = REG_IDLE_TICKS;
  logic [15:0] cfg_data = '0;

  stuffed_frame_receiver #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  int send_idle_pct = 34;
  int recv_idle_pct = 81;
  int items_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // receiver-side shadow of the block
  logic [15:0] idle_reload = IDLE_TICKS_RST;
  logic [7:0] target_code [4] = '{TARGET_A_RST, TARGET_B_RST, TARGET_C_RST, TARGET_D_RST};
  phase_t rx_phase = PH_HUNT;
  logic [15:0] idle_cnt = '0;
  logic [10:0] byte_cnt = '0;
  logic overflow = 1'b0;
  logic [7:0] store_mem [STORE_DEPTH];
  int store_hi = 0;
  out_item_t expected_q[$];

  function automatic bit is_framing_byte(logic [7:0] b);
    return b == START_BYTE || b == END_BYTE || b == ESC_BYTE;
  endfunction

  function automatic void queue_result(kind_t kind, logic [1:0] handler, logic [7:0] command,
                                       logic [9:0] plen, logic [7:0] data, logic last);
    out_item_t r;
    r.kind = kind;
    r.handler = handler;
    r.command = command;
    r.payload_length = plen;
    r.data_byte = data;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void store_data(logic [7:0] b);
    if (byte_cnt < STORE_DEPTH) begin
      store_mem[byte_cnt[9:0]] = b;
      byte_cnt++;
      if (int'(byte_cnt) > store_hi) store_hi = int'(byte_cnt);
    end else begin
      overflow = 1'b1;
    end
  endfunction

  function automatic void close_frame();
    logic [7:0] cmd;
    logic [7:0] status;
    logic [15:0] word;
    logic len_ok;
    logic [7:0] body [4];
    logic [7:0] reply[$];
    cmd = 8'h00;
    status = STATUS_LEN_ERR;
    len_ok = 1'b0;
    if (byte_cnt >= 3) begin
      cmd = store_mem[2];
      if (!overflow) begin
        word = {store_mem[0], store_mem[1]};
        len_ok = (int'(byte_cnt) == int'(word) + 2);
      end
    end
    if (len_ok) begin
      for (int i = 0; i < 4; i++) begin
        if (cmd == target_code[i]) begin
          queue_result(KIND_ACCEPT, 2'(i), cmd, 10'(byte_cnt - 3), 8'h00, 1'b1);
          return;
        end
      end
      status = STATUS_NO_TARGET;
    end
    body[0] = REPLY_HDR0;
    body[1] = REPLY_HDR1;
    body[2] = cmd | CMD_FLAG;
    body[3] = status;
    reply.push_back(START_BYTE);
    foreach (body[i]) begin
      if (is_framing_byte(body[i])) reply.push_back(ESC_BYTE);
      reply.push_back(body[i]);
    end
    reply.push_back(END_BYTE);
    foreach (reply[i])
      queue_result(KIND_REPLY, 2'd0, cmd, 10'd0, reply[i], i == reply.size() - 1);
  endfunction

  function automatic void predict_item(in_item_t it);
    logic [7:0] b;
    b = it.rx_byte;
    case (it.operation)
      OP_TICK: begin
        if (idle_cnt != 0) idle_cnt--;
        else rx_phase = PH_HUNT;
      end
      OP_READ: queue_result(KIND_READ, 2'd0, 8'h00, 10'd0, store_mem[it.read_index], 1'b1);
      OP_BYTE: begin
        if (idle_cnt == 0 && rx_phase == PH_HUNT && b == START_BYTE) begin
          byte_cnt = '0;
          overflow = 1'b0;
          rx_phase = PH_DATA;
        end else if (rx_phase == PH_DATA) begin
          if (b == ESC_BYTE) rx_phase = PH_ESC;
          else if (b == START_BYTE) rx_phase = PH_HUNT;
          else if (b == END_BYTE) begin
            rx_phase = PH_DONE;
            close_frame();
          end else store_data(b);
        end else if (rx_phase == PH_ESC) begin
          if (is_framing_byte(b)) begin
            store_data(b);
            rx_phase = PH_DATA;
          end else begin
            rx_phase = PH_HUNT;
          end
        end
        idle_cnt = idle_reload;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: kind %0d data_byte %0d", out_data.kind, out_data.data_byte);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("handler", want.handler, out_data.handler);
        check_field("command", want.command, out_data.command);
        check_field("payload_length", want.payload_length, out_data.payload_length);
        check_field("data_byte", want.data_byte, out_data.data_byte);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    if (it.operation != OP_UNUSED) items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.operation = OP_BYTE;
    it.rx_byte = b;
    it.read_index = 10'($urandom);
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it.operation = OP_TICK;
    it.rx_byte = 8'($urandom);
    it.read_index = 10'($urandom);
    send_item(it);
  endtask

  task automatic send_read(logic [9:0] idx);
    in_item_t it;
    it.operation = OP_READ;
    it.rx_byte = 8'($urandom);
    it.read_index = idx;
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it.operation = op_t'($urandom_range(3));
    if (it.operation == OP_READ && store_hi == 0) it.operation = OP_TICK;
    it.rx_byte = 8'($urandom);
    it.read_index = (it.operation == OP_READ) ? 10'($urandom_range(store_hi - 1))
                                              : 10'($urandom);
    send_item(it);
  endtask

  task automatic send_data(logic [7:0] b);
    if (is_framing_byte(b)) send_byte(ESC_BYTE);
    send_byte(b);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(5))
      0: b = START_BYTE;
      1: b = END_BYTE;
      2: b = ESC_BYTE;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // ticks until a start byte would open a frame
  task automatic wait_line_idle();
    while (idle_cnt != 0 || rx_phase != PH_HUNT) send_tick();
  endtask

  task automatic send_frame(logic [7:0] body[$], bit wait_idle);
    if (wait_idle) wait_line_idle();
    send_byte(START_BYTE);
    foreach (body[i]) send_data(body[i]);
    send_byte(END_BYTE);
  endtask

  // length word is plen + 1 when word_skew is zero
  task automatic send_cmd_frame(logic [7:0] cmd, int plen, int word_skew, bit wait_idle);
    logic [7:0] body[$];
    logic [15:0] word;
    word = 16'(plen + 1 + word_skew);
    body.push_back(word[15:8]);
    body.push_back(word[7:0]);
    body.push_back(cmd);
    repeat (plen) body.push_back(pick_byte());
    send_frame(body, wait_idle);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IDLE_TICKS: idle_reload = value;
      REG_TARGET_A: target_code[0] = value[7:0];
      REG_TARGET_B: target_code[1] = value[7:0];
      REG_TARGET_C: target_code[2] = value[7:0];
      REG_TARGET_D: target_code[3] = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [15:0] idle, logic [7:0] a, logic [7:0] b,
                             logic [7:0] c, logic [7:0] d);
    drain();
    write_reg(REG_IDLE_TICKS, idle);
    write_reg(REG_TARGET_A, {8'h00, a});
    write_reg(REG_TARGET_B, {8'h00, b});
    write_reg(REG_TARGET_C, {8'h00, c});
    write_reg(REG_TARGET_D, {8'h00, d});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_cmd_frame(TARGET_A_RST, 0, 0, 1);
    send_cmd_frame(TARGET_D_RST, 2, 0, 1);
    send_read(10'd0);
    send_read(10'd4);
    // stray start leaves the countdown loaded, so an early start is dropped
    wait_line_idle();
    send_byte(START_BYTE);
    send_byte(8'h10);
    send_byte(START_BYTE);
    send_byte(START_BYTE);
    send_cmd_frame(TARGET_B_RST, 1, 0, 1);
  endtask

  task automatic test_special_cases();
    logic [7:0] q[$];
    load_config(16'd0, 8'h00, 8'hFF, 8'h55, 8'hAA);
    send_cmd_frame(8'h00, 0, 0, 1);
    send_cmd_frame(8'hFF, 3, 0, 1);
    send_cmd_frame(8'h55, 1, 0, 1);
    send_cmd_frame(8'hAA, 2, 0, 1);
    send_cmd_frame(8'h2A, 0, 0, 1);
    send_cmd_frame(8'h7F, 1, 0, 1);
    send_cmd_frame(8'h10, 2, 3, 1);
    // short frames
    send_frame(q, 1);
    q.push_back(8'h03);
    send_frame(q, 1);
    q.push_back(ESC_BYTE);
    send_frame(q, 1);
    // bad escape
    wait_line_idle();
    send_byte(START_BYTE);
    send_byte(8'h00);
    send_byte(ESC_BYTE);
    send_byte(8'h20);
    send_byte(END_BYTE);
    // bytes after a frame has ended are dropped
    send_cmd_frame(8'h55, 0, 0, 1);
    send_byte(START_BYTE);
    send_byte(8'h33);
    send_byte(END_BYTE);
    send_noise();
    send_tick();
    send_tick();
    send_read(10'd2);
  endtask

  task automatic test_equal_targets();
    in_item_t it;
    load_config(16'hFFFF, 8'h33, 8'h33, 8'h33, 8'h33);
    send_cmd_frame(8'h33, 2, 0, 1);
    send_tick();
    it.operation = OP_UNUSED;
    it.rx_byte = 8'hFF;
    it.read_index = 10'h3FF;
    send_item(it);
    load_config(16'd2, 8'h09, 8'h07, 8'h07, 8'h07);
    send_byte(8'h00);
    send_cmd_frame(8'h07, 1, 0, 1);
    send_cmd_frame(8'h08, 1, 0, 1);
  endtask

  // one byte past a full store; the fill fills every entry
  task automatic test_store_overflow();
    logic [7:0] body[$];
    load_config(16'd1, 8'h42, 8'h43, 8'h44, 8'h45);
    body.push_back(8'h03);
    body.push_back(8'hFF);
    body.push_back(8'h42);
    for (int i = 3; i <= STORE_DEPTH; i++) body.push_back(8'(i * 7));
    send_frame(body, 1);
    send_read(10'h3FF);
    send_read(10'h000);
    send_read(10'h2AA);
    send_read(10'h155);
  endtask

  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_req = 1'b1;
    repeat (12) send_read(10'($urandom_range(store_hi - 1)));
    repeat (3) send_cmd_frame(8'h7F, 1, 2, 1);
    drain();
    send_idle_pct = saved_pct;
    repeat (4) send_read(10'($urandom_range(store_hi - 1)));
  endtask

  task automatic random_sequence();
    int pick;
    logic [7:0] q[$];
    logic [7:0] cmd;
    logic [7:0] bad;
    pick = $urandom_range(99);
    cmd = ($urandom_range(3) != 0) ? target_code[$urandom_range(3)] : 8'($urandom);
    if (pick < 50) begin
      send_cmd_frame(cmd, $urandom_range(8), 0, 1);
    end else if (pick < 60) begin
      send_cmd_frame(cmd, $urandom_range(8), $urandom_range(1, 4), 1);
    end else if (pick < 66) begin
      repeat ($urandom_range(2)) q.push_back(pick_byte());
      send_frame(q, 1);
    end else if (pick < 72) begin
      wait_line_idle();
      send_byte(START_BYTE);
      repeat ($urandom_range(3)) send_data(pick_byte());
      send_byte(START_BYTE);
    end else if (pick < 78) begin
      wait_line_idle();
      send_byte(START_BYTE);
      repeat ($urandom_range(3)) send_data(pick_byte());
      send_byte(ESC_BYTE);
      do bad = 8'($urandom); while (is_framing_byte(bad));
      send_byte(bad);
    end else if (pick < 84) begin
      repeat ($urandom_range(1, 3)) send_read(10'($urandom_range(store_hi - 1)));
    end else if (pick < 90) begin
      send_cmd_frame(cmd, $urandom_range(4), 0, 0);
    end else begin
      repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  task automatic test_random();
    int stop_at;
    logic [7:0] a;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 34 : 0;
      a = 8'($urandom);
      load_config(16'($urandom_range(3)), a,
                  ($urandom_range(3) == 0) ? a : 8'($urandom),
                  8'($urandom), 8'($urandom));
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) random_sequence();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_equal_targets();
    test_store_overflow();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sfr_pkg.sv
hdl/sfr_ram.sv
hdl/stuffed_frame_receiver.sv
sim/tb_top.sv
